// ----- src/lkvc_pkg.sv -----
// Package for the LRU key/value cache.
// Holds the field widths, the operation codes, default sizes and the request
// and response structs. Depends on nothing.
package lkvc_pkg;

  localparam int LKVC_ENTRIES = 8;
  localparam int LKVC_KEY_W   = 32;
  localparam int LKVC_VAL_W   = 64;
  localparam int LKVC_CFG_W   = 4;

  // Capacity register after reset.
  localparam logic [LKVC_CFG_W-1:0] LKVC_CAP_RESET = 4'd8;

  // Operation codes carried in the kind field.
  typedef enum logic {
    LKVC_GET = 1'b0,
    LKVC_SET = 1'b1
  } lkvc_kind_t;

  // One registered request on its way into the store.
  typedef struct packed {
    logic                         kind;
    logic signed [LKVC_KEY_W-1:0] lookup_key;
    logic [LKVC_VAL_W-1:0]        write_value;
  } lkvc_req_t;

  // One response produced by the store.
  typedef struct packed {
    logic                  found;
    logic [LKVC_VAL_W-1:0] read_value;
  } lkvc_rsp_t;

endpackage

// ----- src/lkvc_req_if.sv -----
// Request channel of the LRU key/value cache: valid, ready and the request fields.
// Depends on lkvc_pkg for the field widths.
interface lkvc_req_if
  import lkvc_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [LKVC_KEY_W-1:0] lookup_key;
  logic [LKVC_VAL_W-1:0]        write_value;

  modport source (output valid, output kind, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input kind, input lookup_key, input write_value,
                  output ready);
endinterface

// ----- src/lkvc_rsp_if.sv -----
// Response channel of the LRU key/value cache: valid, ready and the result fields.
// Depends on lkvc_pkg for the field widths.
interface lkvc_rsp_if
  import lkvc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [LKVC_VAL_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

// ----- src/lru_key_value_cache.sv -----
// LRU key/value cache: top level with the input and result registers.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and lkvc_store.
//
// Usage:
//   Requests enter on req (kind, lookup_key, write_value); each transfer is one
//   get or one set. Every request yields exactly one response on rsp
//   (found, read_value), in request order.
//   A request is captured in an input register and processed, once the result
//   register is free or being drained, by a single pass over the store: all
//   slots are compared in parallel and keys, values and recency ranks are
//   updated in that same cycle. The response is then held in a result register,
//   so it reaches rsp through the input register and then the result register.
//   Throughput is one request per cycle while rsp is not stalled, as the store
//   compares and updates its registers in a single pass per request.
//   When rsp is stalled, the result register holds its response, the input
//   register keeps the next request, and req.ready drops once both are full.
//   cfg_write_enable with cfg_write_data sets the capacity before eviction.
//   Reset empties the cache and sets the capacity to eight.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = LKVC_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [LKVC_CFG_W-1:0] cfg_write_data,
  lkvc_req_if.sink              req,
  lkvc_rsp_if.source            rsp
);

  logic [LKVC_CFG_W-1:0] active_entries;
  logic                  in_valid;
  lkvc_req_t             in_req;
  logic                  out_valid;
  lkvc_rsp_t             out_rsp;
  lkvc_rsp_t             store_rsp;
  logic                  advance;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= LKVC_CAP_RESET;
    end else if (cfg_write_enable) begin
      active_entries <= cfg_write_data;
    end
  end

  // A held request moves on when the result register is free or being drained.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_req.kind        <= req.kind;
      in_req.lookup_key  <= req.lookup_key;
      in_req.write_value <= req.write_value;
    end
  end

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk            (clk),
    .rst            (rst),
    .active_entries (active_entries),
    .fire           (advance),
    .req            (in_req),
    .rsp            (store_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= store_rsp;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_rsp.found;
  assign rsp.read_value = out_rsp.read_value;

endmodule

// ----- src/lkvc_store.sv -----
// Register-based associative store with recency ranks for the LRU cache.
// Compares all slots in parallel and applies one get or set per enabled cycle.
// Depends on lkvc_pkg.
module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = LKVC_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [LKVC_CFG_W-1:0] active_entries,
  input  logic                  fire,
  input  lkvc_req_t             req,
  output lkvc_rsp_t             rsp
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  logic [LKVC_KEY_W-1:0] keys   [ENTRIES];
  logic [LKVC_VAL_W-1:0] values [ENTRIES];
  logic [RANK_W-1:0]     ranks  [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [CNT_W-1:0]      fill;

  logic [ENTRIES-1:0]    hit_vec;
  logic [ENTRIES-1:0]    lru_vec;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    ins_vec;
  logic [ENTRIES-1:0]    invalid;
  logic                  hit_any;
  logic [LKVC_VAL_W-1:0] hit_value;
  logic [RANK_W-1:0]     hit_rank;
  logic [RANK_W-1:0]     oldest_rank;
  logic [CNT_W-1:0]      cap;
  logic                  full;
  logic                  is_set;

  // Effective capacity: zero acts as one, values above the depth act as the depth.
  always_comb begin
    if (active_entries == '0) begin
      cap = CNT_W'(1);
    end else if (32'(active_entries) > 32'(ENTRIES)) begin
      cap = CNT_W'(ENTRIES);
    end else begin
      cap = CNT_W'(active_entries);
    end
  end

  assign full        = (fill >= cap);
  assign is_set      = (req.kind == LKVC_SET);
  // The least recent valid slot holds the rank fill-1.
  assign oldest_rank = RANK_W'(fill - CNT_W'(1));

  // Parallel key match and selection of the matching slot's value and rank.
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (keys[i] == req.lookup_key);
      lru_vec[i] = valid[i] && (ranks[i] == oldest_rank);
      hit_value  = hit_value | (values[i] & {LKVC_VAL_W{hit_vec[i]}});
      hit_rank   = hit_rank | (ranks[i] & {RANK_W{hit_vec[i]}});
    end
  end

  assign hit_any  = |hit_vec;
  // Lowest free slot: isolate the lowest set bit of the invalid mask.
  assign invalid  = ~valid;
  assign free_vec = invalid & (~invalid + ENTRIES'(1));
  assign ins_vec  = full ? lru_vec : free_vec;

  // Response of the current request.
  always_comb begin
    rsp.found      = hit_any;
    rsp.read_value = (!is_set && hit_any) ? hit_value : '0;
  end

  // Control state: valid bits, recency ranks and the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else if (fire) begin
      if (hit_any) begin
        // Touch the hit slot; slots more recent than it age by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            ranks[i] <= '0;
          end else if (valid[i] && (ranks[i] < hit_rank)) begin
            ranks[i] <= ranks[i] + RANK_W'(1);
          end
        end
      end else if (is_set) begin
        // Insert as most recent; all other valid slots age by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (ins_vec[i]) begin
            ranks[i] <= '0;
            valid[i] <= 1'b1;
          end else if (valid[i]) begin
            ranks[i] <= ranks[i] + RANK_W'(1);
          end
        end
        if (!full) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  // Keys and values: written by a set, no reset needed.
  always_ff @(posedge clk) begin
    if (fire && is_set) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_any) begin
          if (hit_vec[i]) begin
            values[i] <= req.write_value;
          end
        end else if (ins_vec[i]) begin
          keys[i]   <= req.lookup_key;
          values[i] <= req.write_value;
        end
      end
    end
  end

endmodule
